// ===== hw/rtl/ppr_pkg.sv =====
// Shared constants, types and helper functions for the pivot point rotator.
// Holds the mod-360 reduction helpers and the sine table generator.
// No dependencies.
package ppr_pkg;

	// Default widths of the coordinate fields and of the trig fraction.
	localparam int unsigned COORD_BITS_DEF     = 16;
	localparam int unsigned TRIG_FRAC_BITS_DEF = 14;

	// Fixed field widths.
	localparam int unsigned TURN_BITS  = 16;
	localparam int unsigned ANGLE_BITS = 9;

	// Angle constants in degrees.
	localparam int unsigned QUARTER_TURN  = 90;
	localparam int unsigned HALF_TURN     = 180;
	localparam int unsigned THREE_QUARTER = 270;
	localparam int unsigned FULL_TURN     = 360;
	localparam int unsigned MIRROR_FAR    = 540;

	// Quarter-wave sine table holds entries for 0..90 degrees.
	localparam int unsigned SINE_ENTRIES  = 91;
	localparam int unsigned SINE_IDX_BITS = 7;

	// Mod-360 reduction: an offset that is a multiple of 360 makes the value
	// positive, the low three bits split off the factor 8, and the rest is
	// divided by 45 with a reciprocal that never overestimates.
	localparam int MOD_OFFSET = 33120;
	localparam int MOD_DIV    = 45;
	localparam int MOD_RECIP  = 1456;
	localparam int MOD_SHIFT  = 16;

	// Radians per degree in Q32, used while building the sine table.
	localparam logic [63:0] RAD_PER_DEG_Q32 = 64'd74961321;

	typedef logic [ANGLE_BITS-1:0] angle_t;

	// First half of a mod-360 reduction, carried between two pipeline stages.
	typedef struct packed {
		logic [13:0] v;
		logic [7:0]  q;
		logic [2:0]  lo;
	} mod_part_t;

	// Split a positive 17-bit value and estimate the quotient of its upper 14 bits by 45.
	function automatic mod_part_t mod_split(input logic [16:0] u);
		mod_part_t   p;
		logic [23:0] prod;
		p.v  = u[16:3];
		p.lo = u[2:0];
		prod = 24'(p.v) * 24'(MOD_RECIP);
		p.q  = prod[23:MOD_SHIFT];
		return p;
	endfunction

	// Finish the reduction: one correction step, then put the factor 8 back.
	function automatic angle_t mod_finish(input mod_part_t p);
		logic [13:0] r;
		r = p.v - 14'(p.q) * 14'(MOD_DIV);
		if (r >= 14'(MOD_DIV)) begin
			r = r - 14'(MOD_DIV);
		end
		return {r[5:0], p.lo};
	endfunction

	// sin(k degrees) with frac fraction bits. The Taylor series is summed in
	// Q30 with every term rounded to nearest, clamped to 0..1, then rounded.
	// Only evaluated at elaboration to fill the table.
	function automatic logic [63:0] quarter_sine(input int unsigned k,
		input int unsigned frac);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] sum;
		int unsigned        kk;
		kk   = (k > QUARTER_TURN) ? QUARTER_TURN : k;
		x    = (64'(kk) * RAD_PER_DEG_Q32 + 64'd2) >> 2;
		x2   = (x * x + (64'd1 << 29)) >> 30;
		term = x;
		sum  = signed'(x);
		for (int n = 1; n <= 12; n++) begin
			term = (term * x2 + (64'd1 << 29)) >> 30;
			case (n)
				1:       term = (term + 64'd3) / 64'd6;
				2:       term = (term + 64'd10) / 64'd20;
				3:       term = (term + 64'd21) / 64'd42;
				4:       term = (term + 64'd36) / 64'd72;
				5:       term = (term + 64'd55) / 64'd110;
				6:       term = (term + 64'd78) / 64'd156;
				7:       term = (term + 64'd105) / 64'd210;
				8:       term = (term + 64'd136) / 64'd272;
				9:       term = (term + 64'd171) / 64'd342;
				10:      term = (term + 64'd210) / 64'd420;
				11:      term = (term + 64'd253) / 64'd506;
				12:      term = (term + 64'd300) / 64'd600;
				default: term = term;
			endcase
			if ((n % 2) == 1) begin
				sum = sum - signed'(term);
			end else begin
				sum = sum + signed'(term);
			end
		end
		if (sum < 0) begin
			sum = '0;
		end
		if (sum > signed'(64'd1 << 30)) begin
			sum = signed'(64'd1 << 30);
		end
		return (unsigned'(sum) + (64'd1 << (29 - frac))) >> (30 - frac);
	endfunction

endpackage

// ===== hw/rtl/pivot_point_rotator.sv =====
// Pivot point rotator, top level: a six-stage pipeline that rotates a point
// about a pivot and adjusts the matching arc angles. Depends on ppr_pkg,
// ppr_front, ppr_back and ppr_sine_lut.
//
// Each accepted item gives one result item, and a new item can be accepted in
// every cycle while the output is not stalled, so the sustained rate is one item
// per clock. The pipeline stages, in order: two stages reduce the turn and
// the arc angles modulo 360 (a reciprocal multiply and one correction step),
// one stage reads a 91-entry quarter-wave sine table held as constant logic,
// one stage forms the four rotation products, one rounds, and the last adds
// the pivot, saturates and holds the result. While the output is stalled,
// empty stages still fill, so up to six items can be in flight. Sine and
// cosine carry TRIG_FRAC_BITS fraction bits; coordinates are COORD_BITS wide.
module pivot_point_rotator #(
	parameter int unsigned COORD_BITS     = ppr_pkg::COORD_BITS_DEF,
	parameter int unsigned TRIG_FRAC_BITS = ppr_pkg::TRIG_FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [COORD_BITS-1:0]         point_x,
	input  logic signed [COORD_BITS-1:0]         point_y,
	input  logic signed [COORD_BITS-1:0]         pivot_x,
	input  logic signed [COORD_BITS-1:0]         pivot_y,
	input  logic signed [ppr_pkg::TURN_BITS-1:0] turn_degrees,
	input  ppr_pkg::angle_t                      start_angle,
	input  ppr_pkg::angle_t                      end_angle,
	input  logic                                 mirrored,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [COORD_BITS-1:0]         rotated_x,
	output logic signed [COORD_BITS-1:0]         rotated_y,
	output ppr_pkg::angle_t                      start_out,
	output ppr_pkg::angle_t                      end_out
);
	import ppr_pkg::*;

	logic                         mid_valid;
	logic                         mid_stall;
	angle_t                       turn_s2;
	logic signed [COORD_BITS:0]   dx_s2;
	logic signed [COORD_BITS:0]   dy_s2;
	logic signed [COORD_BITS-1:0] cx_s2;
	logic signed [COORD_BITS-1:0] cy_s2;
	angle_t                       start_s2;
	angle_t                       end_s2;

	ppr_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.up_valid    (in_valid),
		.up_stall    (in_stall),
		.point_x     (point_x),
		.point_y     (point_y),
		.pivot_x     (pivot_x),
		.pivot_y     (pivot_y),
		.turn_degrees(turn_degrees),
		.start_angle (start_angle),
		.end_angle   (end_angle),
		.mirrored    (mirrored),
		.down_valid  (mid_valid),
		.down_stall  (mid_stall),
		.turn_s2     (turn_s2),
		.dx_s2       (dx_s2),
		.dy_s2       (dy_s2),
		.cx_s2       (cx_s2),
		.cy_s2       (cy_s2),
		.start_s2    (start_s2),
		.end_s2      (end_s2)
	);

	ppr_back #(
		.COORD_BITS    (COORD_BITS),
		.TRIG_FRAC_BITS(TRIG_FRAC_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (mid_valid),
		.up_stall (mid_stall),
		.turn_s2  (turn_s2),
		.dx_s2    (dx_s2),
		.dy_s2    (dy_s2),
		.cx_s2    (cx_s2),
		.cy_s2    (cy_s2),
		.start_s2 (start_s2),
		.end_s2   (end_s2),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.rotated_x(rotated_x),
		.rotated_y(rotated_y),
		.start_out(start_out),
		.end_out  (end_out)
	);

endmodule

// ===== hw/rtl/ppr_sine_lut.sv =====
// Quarter-wave sine table, 0..90 degrees, as constant logic.
// Depends on ppr_pkg for the table generator.
module ppr_sine_lut #(
	parameter int unsigned TRIG_FRAC_BITS = ppr_pkg::TRIG_FRAC_BITS_DEF
) (
	input  logic [ppr_pkg::SINE_IDX_BITS-1:0] idx,
	output logic [TRIG_FRAC_BITS:0]           mag
);
	import ppr_pkg::*;

	localparam int unsigned TW = TRIG_FRAC_BITS + 1;

	typedef logic [TW-1:0] lut_t [SINE_ENTRIES];

	function automatic lut_t build_lut();
		lut_t lut;
		for (int k = 0; k < SINE_ENTRIES; k++) begin
			lut[k] = TW'(quarter_sine(k, TRIG_FRAC_BITS));
		end
		return lut;
	endfunction

	localparam lut_t SINE_LUT = build_lut();

	// Indexes above 90 degrees never occur; they read as zero.
	always_comb begin
		if (idx <= SINE_IDX_BITS'(QUARTER_TURN)) begin
			mag = SINE_LUT[idx];
		end else begin
			mag = '0;
		end
	end

endmodule

// ===== hw/rtl/ppr_front.sv =====
// Front pipeline stages: turn reduction, point offset and arc angle update.
// Depends on ppr_pkg for the mod-360 helpers and angle constants.
module ppr_front #(
	parameter int unsigned COORD_BITS = ppr_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                up_valid,
	output logic                                up_stall,
	input  logic signed [COORD_BITS-1:0]        point_x,
	input  logic signed [COORD_BITS-1:0]        point_y,
	input  logic signed [COORD_BITS-1:0]        pivot_x,
	input  logic signed [COORD_BITS-1:0]        pivot_y,
	input  logic signed [ppr_pkg::TURN_BITS-1:0] turn_degrees,
	input  ppr_pkg::angle_t                     start_angle,
	input  ppr_pkg::angle_t                     end_angle,
	input  logic                                mirrored,
	output logic                                down_valid,
	input  logic                                down_stall,
	output ppr_pkg::angle_t                     turn_s2,
	output logic signed [COORD_BITS:0]          dx_s2,
	output logic signed [COORD_BITS:0]          dy_s2,
	output logic signed [COORD_BITS-1:0]        cx_s2,
	output logic signed [COORD_BITS-1:0]        cy_s2,
	output ppr_pkg::angle_t                     start_s2,
	output ppr_pkg::angle_t                     end_s2
);
	import ppr_pkg::*;

	localparam int unsigned CW = COORD_BITS;

	logic v_s1;
	logic v_s2;
	logic adv_s1;
	logic adv_s2;

	// Stage 1 registers.
	mod_part_t           turn_part_s1;
	mod_part_t           a1_part_s1;
	mod_part_t           a2_part_s1;
	logic                a1_le0_s1;
	logic                a2_le0_s1;
	logic                mir_s1;
	logic signed [CW:0]  dx_s1;
	logic signed [CW:0]  dy_s1;
	logic signed [CW-1:0] cx_s1;
	logic signed [CW-1:0] cy_s1;

	// Stage 1 combinational values.
	logic signed [17:0] turn_ext;
	logic signed [17:0] turn_pos;
	logic signed [17:0] a1_ext;
	logic signed [17:0] a2_ext;
	logic signed [17:0] d1;
	logic signed [17:0] d2;
	logic               le1;
	logic               le2;
	logic signed [17:0] e1;
	logic signed [17:0] e2;
	logic signed [17:0] u1;
	logic signed [17:0] u2;

	// Stage 2 combinational values.
	angle_t m1;
	angle_t m2;
	angle_t w1;
	angle_t w2;

	// Reflect a wrapped angle for a mirrored shape.
	function automatic angle_t reflect(input angle_t d);
		if (d <= ANGLE_BITS'(HALF_TURN)) begin
			return ANGLE_BITS'(HALF_TURN) - d;
		end
		return ANGLE_BITS'(MIRROR_FAR) - d;
	endfunction

	// Stall chain: a stage moves when it is empty or the next one moves.
	assign adv_s2     = !v_s2 || !down_stall;
	assign adv_s1     = !v_s1 || adv_s2;
	assign up_stall   = !adv_s1;
	assign down_valid = v_s2;

	// Shift the arc angles by the turn and split all three values for the
	// mod-360 reduction. Positive angles are reduced one below themselves so
	// that positive multiples of a full turn come out as 360.
	always_comb begin
		turn_ext = 18'(turn_degrees);
		turn_pos = turn_ext + 18'(MOD_OFFSET);
		a1_ext   = signed'({9'd0, start_angle});
		a2_ext   = signed'({9'd0, end_angle});
		d1       = mirrored ? a1_ext + turn_ext : a1_ext - turn_ext;
		d2       = mirrored ? a2_ext + turn_ext : a2_ext - turn_ext;
		le1      = d1[17] || (d1 == '0);
		le2      = d2[17] || (d2 == '0);
		e1       = le1 ? d1 : d1 - 18'sd1;
		e2       = le2 ? d2 : d2 - 18'sd1;
		u1       = e1 + 18'(MOD_OFFSET);
		u2       = e2 + 18'(MOD_OFFSET);
	end

	// Finish the arc angle reductions and undo the offset of positive angles;
	// the mirror reflection with its swap follows in the stage 2 payload.
	always_comb begin
		m1 = mod_finish(a1_part_s1);
		m2 = mod_finish(a2_part_s1);
		w1 = a1_le0_s1 ? m1 : m1 + ANGLE_BITS'(1);
		w2 = a2_le0_s1 ? m2 : m2 + ANGLE_BITS'(1);
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				v_s1 <= up_valid;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	// Stage 1 payload.
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			turn_part_s1 <= mod_split(turn_pos[16:0]);
			a1_part_s1   <= mod_split(u1[16:0]);
			a2_part_s1   <= mod_split(u2[16:0]);
			a1_le0_s1    <= le1;
			a2_le0_s1    <= le2;
			mir_s1       <= mirrored;
			dx_s1        <= (CW+1)'(point_x) - (CW+1)'(pivot_x);
			dy_s1        <= (CW+1)'(point_y) - (CW+1)'(pivot_y);
			cx_s1        <= pivot_x;
			cy_s1        <= pivot_y;
		end
	end

	// Stage 2 payload.
	always_ff @(posedge clk) begin
		if (adv_s2) begin
			turn_s2 <= mod_finish(turn_part_s1);
			dx_s2   <= dx_s1;
			dy_s2   <= dy_s1;
			cx_s2   <= cx_s1;
			cy_s2   <= cy_s1;
			if (mir_s1) begin
				start_s2 <= reflect(w2);
				end_s2   <= reflect(w1);
			end else begin
				start_s2 <= w1;
				end_s2   <= w2;
			end
		end
	end

	// The reduced turn stays below a full turn.
	a_turn_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (turn_s2 < ANGLE_BITS'(FULL_TURN)))
		else $error("reduced turn out of range");

	// Adjusted arc angles stay within 0..360.
	a_arc_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (start_s2 <= ANGLE_BITS'(FULL_TURN)) && (end_s2 <= ANGLE_BITS'(FULL_TURN)))
		else $error("arc angle out of range");

	// An item held at stage 2 by a stall is not lost, and its turn and start angle do not change.
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && down_stall |=> v_s2 && $stable(turn_s2) && $stable(start_s2))
		else $error("stage 2 item changed under stall");

endmodule

// ===== hw/rtl/ppr_back.sv =====
// Back pipeline stages: sine/cosine lookup, rotation products, rounding,
// pivot add and saturation. Depends on ppr_pkg and ppr_sine_lut.
module ppr_back #(
	parameter int unsigned COORD_BITS     = ppr_pkg::COORD_BITS_DEF,
	parameter int unsigned TRIG_FRAC_BITS = ppr_pkg::TRIG_FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         up_valid,
	output logic                         up_stall,
	input  ppr_pkg::angle_t              turn_s2,
	input  logic signed [COORD_BITS:0]   dx_s2,
	input  logic signed [COORD_BITS:0]   dy_s2,
	input  logic signed [COORD_BITS-1:0] cx_s2,
	input  logic signed [COORD_BITS-1:0] cy_s2,
	input  ppr_pkg::angle_t              start_s2,
	input  ppr_pkg::angle_t              end_s2,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [COORD_BITS-1:0] rotated_x,
	output logic signed [COORD_BITS-1:0] rotated_y,
	output ppr_pkg::angle_t              start_out,
	output ppr_pkg::angle_t              end_out
);
	import ppr_pkg::*;

	localparam int unsigned CW = COORD_BITS;
	localparam int unsigned FB = TRIG_FRAC_BITS;
	localparam int unsigned SW = FB + 2;
	localparam int unsigned PW = CW + 1 + SW;
	localparam int unsigned RW = PW + 1 - FB;
	localparam int unsigned XW = RW + 1;
	localparam logic signed [SW-1:0] TRIG_ONE = SW'(64'sd1 <<< FB);
	localparam logic signed [XW-1:0] SAT_HI   = XW'((64'sd1 <<< (CW - 1)) - 64'sd1);
	localparam logic signed [XW-1:0] SAT_LO   = XW'(-(64'sd1 <<< (CW - 1)));
	localparam logic signed [PW:0]   RND_HALF = (PW+1)'(64'sd1 <<< (FB - 1));

	logic v_s3;
	logic v_s4;
	logic v_s5;
	logic v_s6;
	logic adv_s3;
	logic adv_s4;
	logic adv_s5;
	logic adv_s6;

	// Quadrant decode and table lookups.
	logic [SINE_IDX_BITS-1:0] sin_idx;
	logic [SINE_IDX_BITS-1:0] cos_idx;
	logic                     sin_neg;
	logic                     cos_neg;
	logic [FB:0]              sin_mag;
	logic [FB:0]              cos_mag;

	// Stage 3 registers.
	logic signed [SW-1:0] s_s3;
	logic signed [SW-1:0] c_s3;
	logic signed [CW:0]   dx_s3;
	logic signed [CW:0]   dy_s3;
	logic signed [CW-1:0] cx_s3;
	logic signed [CW-1:0] cy_s3;
	angle_t               start_s3;
	angle_t               end_s3;

	// Stage 4 registers.
	logic signed [PW-1:0] pxc_s4;
	logic signed [PW-1:0] pys_s4;
	logic signed [PW-1:0] pxs_s4;
	logic signed [PW-1:0] pyc_s4;
	logic signed [CW-1:0] cx_s4;
	logic signed [CW-1:0] cy_s4;
	angle_t               start_s4;
	angle_t               end_s4;

	// Stage 5 registers.
	logic signed [RW-1:0] rnd_x_s5;
	logic signed [RW-1:0] rnd_y_s5;
	logic signed [CW-1:0] cx_s5;
	logic signed [CW-1:0] cy_s5;
	angle_t               start_s5;
	angle_t               end_s5;

	// Stage 5 and 6 combinational values.
	logic signed [PW:0]   sum_x;
	logic signed [PW:0]   sum_y;
	logic signed [XW-1:0] fx;
	logic signed [XW-1:0] fy;

	// Stall chain, from the output register back to the entry stage.
	assign adv_s6    = !v_s6 || !out_stall;
	assign adv_s5    = !v_s5 || adv_s6;
	assign adv_s4    = !v_s4 || adv_s5;
	assign adv_s3    = !v_s3 || adv_s4;
	assign up_stall  = !adv_s3;
	assign out_valid = v_s6;

	// Map the turn to a first-quadrant index and a sign for sine and cosine.
	always_comb begin
		if (turn_s2 <= ANGLE_BITS'(QUARTER_TURN)) begin
			sin_idx = SINE_IDX_BITS'(turn_s2);
			cos_idx = SINE_IDX_BITS'(ANGLE_BITS'(QUARTER_TURN) - turn_s2);
			sin_neg = 1'b0;
			cos_neg = 1'b0;
		end else if (turn_s2 <= ANGLE_BITS'(HALF_TURN)) begin
			sin_idx = SINE_IDX_BITS'(ANGLE_BITS'(HALF_TURN) - turn_s2);
			cos_idx = SINE_IDX_BITS'(turn_s2 - ANGLE_BITS'(QUARTER_TURN));
			sin_neg = 1'b0;
			cos_neg = 1'b1;
		end else if (turn_s2 <= ANGLE_BITS'(THREE_QUARTER)) begin
			sin_idx = SINE_IDX_BITS'(turn_s2 - ANGLE_BITS'(HALF_TURN));
			cos_idx = SINE_IDX_BITS'(ANGLE_BITS'(THREE_QUARTER) - turn_s2);
			sin_neg = 1'b1;
			cos_neg = 1'b1;
		end else begin
			sin_idx = SINE_IDX_BITS'(ANGLE_BITS'(FULL_TURN) - turn_s2);
			cos_idx = SINE_IDX_BITS'(turn_s2 - ANGLE_BITS'(THREE_QUARTER));
			sin_neg = 1'b1;
			cos_neg = 1'b0;
		end
	end

	ppr_sine_lut #(
		.TRIG_FRAC_BITS(TRIG_FRAC_BITS)
	) u_sin_lut (
		.idx(sin_idx),
		.mag(sin_mag)
	);

	ppr_sine_lut #(
		.TRIG_FRAC_BITS(TRIG_FRAC_BITS)
	) u_cos_lut (
		.idx(cos_idx),
		.mag(cos_mag)
	);

	// Rotated offsets, rounded to nearest with ties upward, then the pivot
	// added back.
	always_comb begin
		sum_x = (PW+1)'(pxc_s4) - (PW+1)'(pys_s4) + RND_HALF;
		sum_y = (PW+1)'(pxs_s4) + (PW+1)'(pyc_s4) + RND_HALF;
		fx    = XW'(rnd_x_s5) + XW'(cx_s5);
		fy    = XW'(rnd_y_s5) + XW'(cy_s5);
	end

	// Valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (adv_s3) begin
				v_s3 <= up_valid;
			end
			if (adv_s4) begin
				v_s4 <= v_s3;
			end
			if (adv_s5) begin
				v_s5 <= v_s4;
			end
			if (adv_s6) begin
				v_s6 <= v_s5;
			end
		end
	end

	// Stage 3: signed sine and cosine.
	always_ff @(posedge clk) begin
		if (adv_s3) begin
			s_s3     <= sin_neg ? -signed'({1'b0, sin_mag}) : signed'({1'b0, sin_mag});
			c_s3     <= cos_neg ? -signed'({1'b0, cos_mag}) : signed'({1'b0, cos_mag});
			dx_s3    <= dx_s2;
			dy_s3    <= dy_s2;
			cx_s3    <= cx_s2;
			cy_s3    <= cy_s2;
			start_s3 <= start_s2;
			end_s3   <= end_s2;
		end
	end

	// Stage 4: the four rotation products.
	always_ff @(posedge clk) begin
		if (adv_s4) begin
			pxc_s4   <= PW'(dx_s3) * PW'(c_s3);
			pys_s4   <= PW'(dy_s3) * PW'(s_s3);
			pxs_s4   <= PW'(dx_s3) * PW'(s_s3);
			pyc_s4   <= PW'(dy_s3) * PW'(c_s3);
			cx_s4    <= cx_s3;
			cy_s4    <= cy_s3;
			start_s4 <= start_s3;
			end_s4   <= end_s3;
		end
	end

	// Stage 5: product sums scaled back to coordinate units.
	always_ff @(posedge clk) begin
		if (adv_s5) begin
			rnd_x_s5 <= RW'(sum_x >>> FB);
			rnd_y_s5 <= RW'(sum_y >>> FB);
			cx_s5    <= cx_s4;
			cy_s5    <= cy_s4;
			start_s5 <= start_s4;
			end_s5   <= end_s4;
		end
	end

	// Stage 6: output register with saturation to the coordinate range.
	always_ff @(posedge clk) begin
		if (adv_s6) begin
			if (fx > SAT_HI) begin
				rotated_x <= CW'(SAT_HI);
			end else if (fx < SAT_LO) begin
				rotated_x <= CW'(SAT_LO);
			end else begin
				rotated_x <= CW'(fx);
			end
			if (fy > SAT_HI) begin
				rotated_y <= CW'(SAT_HI);
			end else if (fy < SAT_LO) begin
				rotated_y <= CW'(SAT_LO);
			end else begin
				rotated_y <= CW'(fy);
			end
			start_out <= start_s5;
			end_out   <= end_s5;
		end
	end

	// Sine and cosine never exceed one in magnitude.
	a_trig_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 |-> (s_s3 <= TRIG_ONE) && (s_s3 >= -TRIG_ONE)
			&& (c_s3 <= TRIG_ONE) && (c_s3 >= -TRIG_ONE))
		else $error("trig value exceeds one");

	// A cosine of exactly one comes only with a zero sine.
	a_trig_axis: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && (c_s3 == TRIG_ONE) |-> (s_s3 == '0))
		else $error("quadrant decode mismatch");

	// An item waiting at stage 5 behind a stalled output register is kept, with its rounded sums unchanged.
	a_s5_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !adv_s6 |=> v_s5 && $stable(rnd_x_s5) && $stable(rnd_y_s5))
		else $error("stage 5 item changed under stall");

endmodule
